>>> hw/rtl/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg: shared types and constants of the quaternion ALU
// Fixed-point format, pipeline widths, mode codes and the operand tables
// used by the Hamilton product.
// ----------------------------------------------------------------------------
package qalu_pkg;

	// fixed-point format and datapath widths
	localparam int FRAC_BITS = 28;
	localparam int CW = 32;                 // component width
	localparam int PW = 2 * CW;             // one product
	localparam int AW = PW + 2;             // pair of products with sign
	localparam int TW = PW + 3;             // sum of four products plus rounding
	localparam int SW = PW + 1;             // sum of four squares
	localparam int RB = CW + 1;             // square root bits
	localparam int QB = FRAC_BITS + 1;      // quotient bits
	localparam int NW = RB + FRAC_BITS;     // dividend width

	// front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	// back-end latency: three product stages, root stages, quotient stages, output
	localparam int LAT = RB + QB + 4;

	typedef enum logic [1:0] {
		MODE_PROD = 2'd0,
		MODE_VEC  = 2'd1,
		MODE_CONJ = 2'd2,
		MODE_NORM = 2'd3
	} mode_t;

	typedef logic signed [CW-1:0] comp_t;
	typedef comp_t [3:0] quat_t;

	localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};

	// component positions
	localparam logic [1:0] CI_W = 2'd0;
	localparam logic [1:0] CI_X = 2'd1;
	localparam logic [1:0] CI_Y = 2'd2;
	localparam logic [1:0] CI_Z = 2'd3;

	// Hamilton product terms: component c is the signed sum of A[PA] * B[PB]
	localparam logic [1:0] PA_IDX [4][4] = '{
		'{CI_W, CI_X, CI_Y, CI_Z},
		'{CI_X, CI_W, CI_Y, CI_Z},
		'{CI_Y, CI_W, CI_Z, CI_X},
		'{CI_Z, CI_W, CI_X, CI_Y}
	};
	localparam logic [1:0] PB_IDX [4][4] = '{
		'{CI_W, CI_X, CI_Y, CI_Z},
		'{CI_W, CI_X, CI_Z, CI_Y},
		'{CI_W, CI_Y, CI_X, CI_Z},
		'{CI_W, CI_Z, CI_Y, CI_X}
	};

	// one classified operation waiting in the queue
	typedef struct packed {
		mode_t mode;
		quat_t a;
		quat_t b;
	} entry_t;

	// data that rides along the root and quotient pipelines
	typedef struct packed {
		mode_t mode;
		quat_t r;
		logic  sat;
		quat_t a;
	} side_t;

endpackage

>>> hw/rtl/quaternion_alu.sv
// Components are Q3.28; done strobes each result after its command has passed the queue and the back end.
// Throughput: one command per cycle; the back end never stalls, so busy stays low.
// The latency is set by the bit-per-stage square root and the bit-per-stage divider.
// Results cannot be held off: done marks each result for exactly one cycle.
// Reset (arst_n low) empties the queue and all stage valids; commands in flight are lost.
// ----------------------------------------------------------------------------
// quaternion_alu: quaternion product, vector product, conjugate and normalize
// Intake and classification feed a short queue; a fixed-latency pipeline of
// multipliers, square root and dividers executes each transaction in order.
// ----------------------------------------------------------------------------
module quaternion_alu import qalu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           mode,
	input  logic signed [CW-1:0] a_w,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] a_z,
	input  logic signed [CW-1:0] b_w,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic signed [CW-1:0] b_z,
	output logic                 done,
	output logic signed [CW-1:0] r_w,
	output logic signed [CW-1:0] r_x,
	output logic signed [CW-1:0] r_y,
	output logic signed [CW-1:0] r_z,
	output logic                 saturated,
	output logic                 zero_length
);

	logic   full;
	logic   push;
	entry_t entry;
	logic   head_vld;
	entry_t head;

	assign busy = full;

	qalu_front u_front (
		.start (start),
		.full  (full),
		.mode  (mode),
		.a_w   (a_w),
		.a_x   (a_x),
		.a_y   (a_y),
		.a_z   (a_z),
		.b_w   (b_w),
		.b_x   (b_x),
		.b_y   (b_y),
		.b_z   (b_z),
		.push  (push),
		.entry (entry)
	);

	qalu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (entry),
		.full     (full),
		.head_vld (head_vld),
		.head     (head)
	);

	qalu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (head_vld),
		.in_entry    (head),
		.done        (done),
		.r_w         (r_w),
		.r_x         (r_x),
		.r_y         (r_y),
		.r_z         (r_z),
		.saturated   (saturated),
		.zero_length (zero_length)
	);

endmodule

>>> hw/rtl/qalu_front.sv
// ----------------------------------------------------------------------------
// qalu_front: command intake
// Accepts a transaction when the queue has room and classifies it: the vector
// mode gets a zero scalar in B, normalize reuses A as B to form squares.
// ----------------------------------------------------------------------------
module qalu_front import qalu_pkg::*; (
	input  logic              start,
	input  logic              full,
	input  logic [1:0]        mode,
	input  logic signed [CW-1:0] a_w,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] a_z,
	input  logic signed [CW-1:0] b_w,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic signed [CW-1:0] b_z,
	output logic              push,
	output entry_t            entry
);

	// accept only with room in the queue
	assign push = start & ~full;

	// classify the operation and shape operand B
	always_comb begin
		mode_t md;
		md = mode_t'(mode);
		entry.mode = md;
		entry.a = {a_z, a_y, a_x, a_w};
		unique case (md) inside
			MODE_VEC:             entry.b = {b_z, b_y, b_x, comp_t'(0)};
			MODE_NORM:            entry.b = {a_z, a_y, a_x, a_w};
			MODE_PROD, MODE_CONJ: entry.b = {b_z, b_y, b_x, b_w};
			default:              entry.b = {b_z, b_y, b_x, b_w};
		endcase
	end

endmodule

>>> hw/rtl/qalu_queue.sv
// ----------------------------------------------------------------------------
// qalu_queue: front-to-back queue
// Small register FIFO between intake and execution. The back end drains one
// entry in every cycle that the queue holds one.
// ----------------------------------------------------------------------------
module qalu_queue import qalu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   full,
	output logic   head_vld,
	output entry_t head
);

	entry_t         mem_q [QDEPTH];
	logic [QPW-1:0] wptr_q;
	logic [QPW-1:0] rptr_q;
	logic [QCW-1:0] cnt_q;
	logic           pop;

	assign full     = (cnt_q == QCW'(QDEPTH));
	assign head_vld = (cnt_q != '0);
	assign pop      = head_vld;
	assign head     = mem_q[rptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue pushed while full");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH)) else $error("queue count out of range");
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> head_vld) else $error("queue full with no head entry");
`endif

endmodule

>>> hw/rtl/qalu_sqrt.sv
// ----------------------------------------------------------------------------
// qalu_sqrt: pipelined integer square root
// One root bit per stage, most significant first, on the exact sum of
// squares. The side data travels with each transaction.
// ----------------------------------------------------------------------------
module qalu_sqrt import qalu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [SW-1:0] in_sq,
	input  side_t         in_side,
	output logic          out_vld,
	output logic [RB-1:0] out_root,
	output side_t         out_side
);

	localparam int TRW = 2 * RB + 1;

	logic          vld_s  [RB];
	logic [SW-1:0] rem_s  [RB];
	logic [RB-1:0] root_s [RB];
	side_t         side_s [RB];

	for (genvar k = 0; k < RB; k++) begin : g_stage
		localparam int BIT = RB - 1 - k;
		logic           vld_i;
		logic [SW-1:0]  rem_i;
		logic [RB-1:0]  root_i;
		side_t          side_i;
		logic [TRW-1:0] trial;
		logic           take;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rem_i  = in_sq;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// try this root bit: (2*root + 2^b) * 2^b against the remainder
		assign trial = (TRW'({root_i, 1'b0}) | (TRW'(1) << BIT)) << BIT;
		assign take  = (trial <= TRW'(rem_i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? rem_i - trial[SW-1:0] : rem_i;
			root_s[k] <= take ? (root_i | (RB'(1) << BIT)) : root_i;
			side_s[k] <= side_i;
		end
	end

	assign out_vld  = vld_s[RB-1];
	assign out_root = root_s[RB-1];
	assign out_side = side_s[RB-1];

endmodule

>>> hw/rtl/qalu_div.sv
// ----------------------------------------------------------------------------
// qalu_div: four-lane pipelined divider for normalize
// Each lane divides |A_i| * 2^FRAC_BITS plus half the length by the length,
// one quotient bit per stage, and restores the sign at the end.
// ----------------------------------------------------------------------------
module qalu_div import qalu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [RB-1:0] in_len,
	input  side_t         in_side,
	output logic          out_vld,
	output quat_t         out_r,
	output logic          out_zero,
	output side_t         out_side
);

	logic          vld_s  [QB];
	logic [NW-1:0] rem_s  [QB][4];
	logic [QB-1:0] quo_s  [QB][4];
	logic          neg_s  [QB][4];
	logic [RB-1:0] dvs_s  [QB];
	logic          zero_s [QB];
	side_t         side_s [QB];

	// form dividends and signs on entry
	logic [NW-1:0] e_rem [4];
	logic          e_neg [4];

	always_comb begin
		logic [CW-1:0] mag;
		for (int l = 0; l < 4; l++) begin
			e_neg[l] = in_side.a[l][CW-1];
			mag = e_neg[l] ? (CW'(0) - CW'(in_side.a[l])) : CW'(in_side.a[l]);
			e_rem[l] = (NW'(mag) << FRAC_BITS) + NW'(in_len >> 1);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int BIT = QB - 1 - k;
		logic          vld_i;
		logic [NW-1:0] rem_i [4];
		logic [QB-1:0] quo_i [4];
		logic          neg_i [4];
		logic [RB-1:0] dvs_i;
		logic          zero_i;
		side_t         side_i;
		logic [NW-1:0] trial;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 4; l++) begin
					rem_i[l] = e_rem[l];
					quo_i[l] = '0;
					neg_i[l] = e_neg[l];
				end
			end
			assign vld_i  = in_vld;
			assign zero_i = (in_len == '0);
			assign dvs_i  = (in_len == '0) ? RB'(1) : in_len;
			assign side_i = in_side;
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 4; l++) begin
					rem_i[l] = rem_s[k-1][l];
					quo_i[l] = quo_s[k-1][l];
					neg_i[l] = neg_s[k-1][l];
				end
			end
			assign vld_i  = vld_s[k-1];
			assign zero_i = zero_s[k-1];
			assign dvs_i  = dvs_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = NW'(dvs_i) << BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		// subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			for (int l = 0; l < 4; l++) begin
				if (rem_i[l] >= trial) begin
					rem_s[k][l] <= rem_i[l] - trial;
					quo_s[k][l] <= quo_i[l] | (QB'(1) << BIT);
				end else begin
					rem_s[k][l] <= rem_i[l];
					quo_s[k][l] <= quo_i[l];
				end
				neg_s[k][l] <= neg_i[l];
			end
			dvs_s[k]  <= dvs_i;
			zero_s[k] <= zero_i;
			side_s[k] <= side_i;
		end
	end

	// restore signs
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			out_r[l] = neg_s[QB-1][l] ? comp_t'(CW'(0) - CW'(quo_s[QB-1][l]))
			                          : comp_t'(CW'(quo_s[QB-1][l]));
		end
	end

	assign out_vld  = vld_s[QB-1];
	assign out_zero = zero_s[QB-1];
	assign out_side = side_s[QB-1];

endmodule

>>> hw/rtl/qalu_back.sv
// ----------------------------------------------------------------------------
// qalu_back: execution pipeline
// Sixteen products, two adder stages with rounding and saturation, then the
// square root and the divider for normalize; every mode takes the same path
// so results leave in order.
// ----------------------------------------------------------------------------
module qalu_back import qalu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_vld,
	input  entry_t in_entry,
	output logic   done,
	output comp_t  r_w,
	output comp_t  r_x,
	output comp_t  r_y,
	output comp_t  r_z,
	output logic   saturated,
	output logic   zero_length
);

	localparam logic [TW-1:0] RND = TW'(1) << (FRAC_BITS - 1);

	// stage 1: products and conjugate
	logic                 v_s1;
	mode_t                mode_s1;
	quat_t                a_s1;
	quat_t                conj_s1;
	logic                 csat_s1;
	logic signed [PW-1:0] prod_s1 [4][4];
	quat_t                conj_d;
	logic                 csat_d;

	always_comb begin
		conj_d[CI_W] = in_entry.a[CI_W];
		csat_d = 1'b0;
		for (int k = 1; k < 4; k++) begin
			if (in_entry.a[k] == CMIN) begin
				conj_d[k] = CMAX;
				csat_d = 1'b1;
			end else begin
				conj_d[k] = -in_entry.a[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= in_entry.mode;
		a_s1    <= in_entry.a;
		conj_s1 <= conj_d;
		csat_s1 <= csat_d;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				prod_s1[c][k] <= $signed(in_entry.a[PA_IDX[c][k]])
				               * $signed(in_entry.b[PB_IDX[c][k]]);
			end
		end
	end

	// stage 2: signed pair sums
	logic                 v_s2;
	mode_t                mode_s2;
	quat_t                a_s2;
	quat_t                conj_s2;
	logic                 csat_s2;
	logic signed [AW-1:0] pr0_s2 [4];
	logic signed [AW-1:0] pr1_s2 [4];
	logic signed [AW-1:0] pr0_d  [4];
	logic signed [AW-1:0] pr1_d  [4];

	always_comb begin
		logic signed [AW-1:0] t [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				t[k] = {{(AW-PW){prod_s1[c][k][PW-1]}}, prod_s1[c][k]};
			end
			if (c == 0) begin
				if (mode_s1 == MODE_NORM) begin
					pr0_d[c] = t[0] + t[1];
					pr1_d[c] = t[2] + t[3];
				end else begin
					pr0_d[c] = t[0] - t[1];
					pr1_d[c] = -t[2] - t[3];
				end
			end else begin
				pr0_d[c] = t[0] + t[1];
				pr1_d[c] = t[2] - t[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		a_s2    <= a_s1;
		conj_s2 <= conj_s1;
		csat_s2 <= csat_s1;
		pr0_s2  <= pr0_d;
		pr1_s2  <= pr1_d;
	end

	// stage 3: final sum, round, scale and saturate
	logic          v_s3;
	side_t         side_s3;
	logic [SW-1:0] sq_s3;
	side_t         side_d;
	logic [SW-1:0] sq_d;

	always_comb begin
		logic [TW-1:0]           tot;
		logic [TW-1:0]           sr;
		logic [TW-CW-FRAC_BITS:0] hi;
		quat_t                   pr;
		logic                    psat;
		psat = 1'b0;
		sq_d = '0;
		for (int c = 0; c < 4; c++) begin
			tot = {{(TW-AW){pr0_s2[c][AW-1]}}, pr0_s2[c]}
			    + {{(TW-AW){pr1_s2[c][AW-1]}}, pr1_s2[c]};
			if (c == 0) begin
				sq_d = tot[SW-1:0];
			end
			sr = tot + RND;
			hi = sr[TW-1:CW-1+FRAC_BITS];
			if ((hi == '0) || (hi == '1)) begin
				pr[c] = comp_t'(sr[CW-1+FRAC_BITS:FRAC_BITS]);
			end else begin
				pr[c] = sr[TW-1] ? CMIN : CMAX;
				psat = 1'b1;
			end
		end
		side_d.mode = mode_s2;
		side_d.a    = a_s2;
		unique case (mode_s2) inside
			MODE_PROD, MODE_VEC: begin
				side_d.r   = pr;
				side_d.sat = psat;
			end
			MODE_CONJ: begin
				side_d.r   = conj_s2;
				side_d.sat = csat_s2;
			end
			MODE_NORM: begin
				side_d.r   = '0;
				side_d.sat = 1'b0;
			end
			default: begin
				side_d.r   = '0;
				side_d.sat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_d;
		sq_s3   <= sq_d;
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// length and quotients
	logic          rt_vld;
	logic [RB-1:0] rt_len;
	side_t         rt_side;
	logic          dv_vld;
	quat_t         dv_r;
	logic          dv_zero;
	side_t         dv_side;

	qalu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s3),
		.in_sq    (sq_s3),
		.in_side  (side_s3),
		.out_vld  (rt_vld),
		.out_root (rt_len),
		.out_side (rt_side)
	);

	qalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (rt_vld),
		.in_len   (rt_len),
		.in_side  (rt_side),
		.out_vld  (dv_vld),
		.out_r    (dv_r),
		.out_zero (dv_zero),
		.out_side (dv_side)
	);

	// output register: pick normalize quotients or the carried result
	logic  done_q;
	quat_t r_q;
	logic  sat_q;
	logic  zl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_side.mode == MODE_NORM) begin
			r_q   <= dv_zero ? '0 : dv_r;
			sat_q <= 1'b0;
			zl_q  <= dv_zero;
		end else begin
			r_q   <= dv_side.r;
			sat_q <= dv_side.sat;
			zl_q  <= 1'b0;
		end
	end

	assign done        = done_q;
	assign r_w         = r_q[CI_W];
	assign r_x         = r_q[CI_X];
	assign r_y         = r_q[CI_Y];
	assign r_z         = r_q[CI_Z];
	assign saturated   = sat_q;
	assign zero_length = zl_q;

`ifndef SYNTH
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(in_vld, LAT)) else $error("result strobe without a transaction");
	a_strobe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_vld, LAT) |-> done_q) else $error("transaction missed its result strobe");
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && zl_q |-> !sat_q && (r_q == '0)) else $error("zero length with data");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for quaternion_alu
// Drives product, vector product, conjugate and normalize commands with random
// gaps and compares every done strobe against an in-order queue of predicted
// results computed with wide exact arithmetic inside the testbench.
// ----------------------------------------------------------------------------
module tb;
	import qalu_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		quat_t r;
		logic  sat;
		logic  zl;
	} qres_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	logic  [1:0] mode;
	comp_t a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
	logic  done;
	comp_t r_w, r_x, r_y, r_z;
	logic  saturated, zero_length;

	qres_t pending_results[$];
	int    errors;
	int    idle_cycles;
	int    mode_count[4];
	int    results_seen;
	bit    no_gaps;

	quaternion_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.done(done), .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
		.saturated(saturated), .zero_length(zero_length)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// round half up, scale down, clamp to the component range
	function automatic comp_t scale_clamp(input logic signed [127:0] acc, inout logic sat);
		logic signed [127:0] t;
		t = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (t > 128'sd2147483647) begin
			sat = 1'b1;
			return CMAX;
		end
		if (t < -128'sd2147483648) begin
			sat = 1'b1;
			return CMIN;
		end
		return comp_t'(t[31:0]);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] num);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > num)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num = num - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// expected result of one command
	function automatic qres_t quat_predict(input mode_t m, input quat_t a, input quat_t b);
		qres_t o;
		logic signed [127:0] aw, ax, ay, az, bw, bx, by, bz;
		logic [65:0] sum_sq;
		logic [63:0] len, mag, quo;
		logic sat;
		sat = 1'b0;
		o = '0;
		aw = a[CI_W]; ax = a[CI_X]; ay = a[CI_Y]; az = a[CI_Z];
		bw = (m == MODE_VEC) ? 128'sd0 : 128'(b[CI_W]);
		bx = b[CI_X]; by = b[CI_Y]; bz = b[CI_Z];
		case (m)
			MODE_PROD, MODE_VEC: begin
				o.r[CI_W] = scale_clamp(aw*bw - ax*bx - ay*by - az*bz, sat);
				o.r[CI_X] = scale_clamp(ax*bw + aw*bx + ay*bz - az*by, sat);
				o.r[CI_Y] = scale_clamp(ay*bw + aw*by + az*bx - ax*bz, sat);
				o.r[CI_Z] = scale_clamp(az*bw + aw*bz + ax*by - ay*bx, sat);
			end
			MODE_CONJ: begin
				o.r[CI_W] = a[CI_W];
				for (int k = 1; k < 4; k++) begin
					if (a[k] == CMIN) begin
						o.r[k] = CMAX;
						sat = 1'b1;
					end else begin
						o.r[k] = -a[k];
					end
				end
			end
			default: begin
				sum_sq = 66'(aw*aw) + 66'(ax*ax) + 66'(ay*ay) + 66'(az*az);
				if (sum_sq == 0) begin
					o.zl = 1'b1;
				end else begin
					len = sum_sq[65:64] != 0 ? 64'd1 << 32 : int_sqrt(sum_sq[63:0]);
					for (int k = 0; k < 4; k++) begin
						mag = a[k] < 0 ? 64'(-128'(a[k])) : 64'(a[k]);
						quo = ((mag << FRAC_BITS) + (len >> 1)) / len;
						o.r[k] = a[k] < 0 ? comp_t'(-quo) : comp_t'(quo);
					end
				end
			end
		endcase
		o.sat = sat;
		return o;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// full range, near unit, extremes or zero
	function automatic comp_t rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return comp_t'($urandom);
		if (r < 8)
			return comp_t'($urandom_range(0, 32'h2000_0000)) - comp_t'(32'h1000_0000);
		if (r == 8)
			return $urandom_range(0, 1) ? CMAX : CMIN;
		return '0;
	endfunction

	function automatic quat_t rand_quat();
		quat_t q;
		for (int k = 0; k < 4; k++)
			q[k] = rand_comp();
		return q;
	endfunction

	// send one command and hold until accepted
	task automatic send_cmd(input mode_t m, input quat_t a, input quat_t b);
		int gap;
		mode  <= m;
		a_w <= a[CI_W]; a_x <= a[CI_X]; a_y <= a[CI_Y]; a_z <= a[CI_Z];
		b_w <= b[CI_W]; b_x <= b[CI_X]; b_y <= b[CI_Y]; b_z <= b[CI_Z];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(quat_predict(m, a, b));
		mode_count[m]++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic quat_t mkq(input comp_t w, input comp_t x, input comp_t y, input comp_t z);
		quat_t q;
		q[CI_W] = w; q[CI_X] = x; q[CI_Y] = y; q[CI_Z] = z;
		return q;
	endfunction

	task automatic test_directed();
		quat_t one, zero, maxq, minq;
		one  = mkq(comp_t'(1 <<< FRAC_BITS), 0, 0, 0);
		zero = '0;
		maxq = mkq(CMAX, CMAX, CMAX, CMAX);
		minq = mkq(CMIN, CMIN, CMIN, CMIN);
		// identity and basis products
		send_cmd(MODE_PROD, one, maxq);
		send_cmd(MODE_PROD, mkq(0, comp_t'(1 <<< FRAC_BITS), 0, 0),
			mkq(0, 0, comp_t'(1 <<< FRAC_BITS), 0));
		// saturating products at both signs
		send_cmd(MODE_PROD, maxq, maxq);
		send_cmd(MODE_PROD, minq, minq);
		send_cmd(MODE_PROD, maxq, minq);
		send_cmd(MODE_PROD, zero, zero);
		// vector product ignores b_w
		send_cmd(MODE_VEC, one, mkq(CMAX, 1, 2, 3));
		send_cmd(MODE_VEC, minq, minq);
		send_cmd(MODE_VEC, maxq, maxq);
		// conjugate, including negation of the minimum
		send_cmd(MODE_CONJ, minq, maxq);
		send_cmd(MODE_CONJ, maxq, zero);
		send_cmd(MODE_CONJ, mkq(-1, 1, 0, CMIN), zero);
		// normalize: zero length, overflowing sum of squares, tiny and large values
		send_cmd(MODE_NORM, zero, maxq);
		send_cmd(MODE_NORM, minq, zero);
		send_cmd(MODE_NORM, maxq, zero);
		send_cmd(MODE_NORM, mkq(0, 0, 0, 1), zero);
		send_cmd(MODE_NORM, mkq(-1, 0, 0, 0), zero);
		send_cmd(MODE_NORM, mkq(3, 4, 0, 0), zero);
		send_cmd(MODE_NORM, mkq(CMIN, 0, 0, 0), zero);
		send_cmd(MODE_NORM, mkq(CMIN, CMIN, CMIN, CMAX), zero);
	endtask

	task automatic test_mode(input mode_t m, input int n);
		for (int i = 0; i < n; i++)
			send_cmd(m, rand_quat(), rand_quat());
	endtask

	task automatic test_mixed(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				no_gaps = ~no_gaps;
			send_cmd(mode_t'($urandom_range(0, 3)), rand_quat(), rand_quat());
		end
		no_gaps = 1'b0;
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		qres_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (r_w !== e.r[CI_W]) begin
					$error("r_w expected %0d actual %0d", e.r[CI_W], r_w);
					errors++;
				end
				if (r_x !== e.r[CI_X]) begin
					$error("r_x expected %0d actual %0d", e.r[CI_X], r_x);
					errors++;
				end
				if (r_y !== e.r[CI_Y]) begin
					$error("r_y expected %0d actual %0d", e.r[CI_Y], r_y);
					errors++;
				end
				if (r_z !== e.r[CI_Z]) begin
					$error("r_z expected %0d actual %0d", e.r[CI_Z], r_z);
					errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0b actual %0b", e.sat, saturated);
					errors++;
				end
				if (zero_length !== e.zl) begin
					$error("zero_length expected %0b actual %0b", e.zl, zero_length);
					errors++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		results_seen = 0;
		no_gaps = 1'b0;
		start <= 1'b0;
		mode <= MODE_PROD;
		a_w <= '0; a_x <= '0; a_y <= '0; a_z <= '0;
		b_w <= '0; b_x <= '0; b_y <= '0; b_z <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mode(MODE_PROD, 400);
		test_mode(MODE_VEC, 300);
		test_mode(MODE_CONJ, 200);
		test_mode(MODE_NORM, 400);
		test_mixed(530);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (FRAC_BITS + 50) @(posedge clk);

		$display("Covered %0d product, %0d vector, %0d conjugate, %0d normalize transactions;",
			mode_count[MODE_PROD], mode_count[MODE_VEC], mode_count[MODE_CONJ],
			mode_count[MODE_NORM]);
		$display("%0d results checked, %0d mismatches.", results_seen, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
